// ----- rtl/core/lfp_pkg.sv -----
// ----------------------------------------------------------------------------
// lfp_pkg
// shared types, constants and the sensor decode for the line follower steering
// ----------------------------------------------------------------------------
package lfp_pkg;

    // fixed field widths
    localparam int SENSOR_W = 5;
    localparam int ERR_W    = 3;
    localparam int ABS_W    = 2;
    localparam int KP_W     = 8;
    localparam int KI_W     = 10;
    localparam int KD_W     = 8;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;

    // reset values of the gain registers
    localparam logic [KP_W-1:0] KP_RST = 8'd60;
    localparam logic [KI_W-1:0] KI_RST = 10'd205;
    localparam logic [KD_W-1:0] KD_RST = 8'd20;

    // one-hot-low sensor patterns, bit4 is the leftmost sensor
    localparam logic [SENSOR_W-1:0] PAT_ERR_M2 = 5'h1E;
    localparam logic [SENSOR_W-1:0] PAT_ERR_M1 = 5'h1D;
    localparam logic [SENSOR_W-1:0] PAT_ERR_Z  = 5'h1B;
    localparam logic [SENSOR_W-1:0] PAT_ERR_P1 = 5'h17;
    localparam logic [SENSOR_W-1:0] PAT_ERR_P2 = 5'h0F;

    // position error codes
    localparam logic signed [ERR_W-1:0] ERR_M2 = -3'sd2;
    localparam logic signed [ERR_W-1:0] ERR_M1 = -3'sd1;
    localparam logic signed [ERR_W-1:0] ERR_Z  = 3'sd0;
    localparam logic signed [ERR_W-1:0] ERR_P1 = 3'sd1;
    localparam logic signed [ERR_W-1:0] ERR_P2 = 3'sd2;

    // register word index on the config port
    typedef enum logic [2:0] {
        REG_BASE_SPEED  = 3'd0,
        REG_KP          = 3'd1,
        REG_KI_Q8       = 3'd2,
        REG_KD          = 3'd3,
        REG_MOTOR_LIMIT = 3'd4
    } t_reg_idx;

    // gain set handed from the register file to the datapath
    typedef struct packed {
        logic [KP_W-1:0] kp;
        logic [KI_W-1:0] ki_q8;
        logic [KD_W-1:0] kd;
    } t_gain;

    // sensor decode result
    typedef struct packed {
        logic                    hit;
        logic signed [ERR_W-1:0] err;
    } t_decode;

    function automatic t_decode decode_sensors(input logic [SENSOR_W-1:0] bits);
        t_decode d;
        d.hit = 1'b1;
        d.err = ERR_Z;
        unique case (bits)
            PAT_ERR_M2: d.err = ERR_M2;
            PAT_ERR_M1: d.err = ERR_M1;
            PAT_ERR_Z:  d.err = ERR_Z;
            PAT_ERR_P1: d.err = ERR_P1;
            PAT_ERR_P2: d.err = ERR_P2;
            default:    d.hit = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/core/lfp_cfg.sv -----
// ----------------------------------------------------------------------------
// lfp_cfg
// apb register file holding base speed, pid gains and motor limit
// ----------------------------------------------------------------------------
module lfp_cfg #(
    parameter int DUTY_WIDTH = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfp_pkg::APB_AW-1:0]  paddr,
    input  logic [lfp_pkg::APB_DW-1:0]  pwdata,
    output logic [lfp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [DUTY_WIDTH-1:0]       o_base_speed,
    output logic [DUTY_WIDTH-1:0]       o_motor_limit,
    output lfp_pkg::t_gain              o_gain
);
    import lfp_pkg::*;

    localparam logic [DUTY_WIDTH-1:0] BASE_RST  = DUTY_WIDTH'(350);
    localparam logic [DUTY_WIDTH-1:0] LIMIT_RST = DUTY_WIDTH'(700);

    logic [DUTY_WIDTH-1:0] r_base_speed;
    logic [DUTY_WIDTH-1:0] r_motor_limit;
    logic [KP_W-1:0]       r_kp;
    logic [KI_W-1:0]       r_ki_q8;
    logic [KD_W-1:0]       r_kd;
    logic                  w_wr;
    t_reg_idx              w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);

    // register writes, unused word slots are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed  <= BASE_RST;
            r_motor_limit <= LIMIT_RST;
            r_kp          <= KP_RST;
            r_ki_q8       <= KI_RST;
            r_kd          <= KD_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BASE_SPEED:  r_base_speed  <= pwdata[DUTY_WIDTH-1:0];
                REG_KP:          r_kp          <= pwdata[KP_W-1:0];
                REG_KI_Q8:       r_ki_q8       <= pwdata[KI_W-1:0];
                REG_KD:          r_kd          <= pwdata[KD_W-1:0];
                REG_MOTOR_LIMIT: r_motor_limit <= pwdata[DUTY_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_BASE_SPEED:  prdata = APB_DW'(r_base_speed);
            REG_KP:          prdata = APB_DW'(r_kp);
            REG_KI_Q8:       prdata = APB_DW'(r_ki_q8);
            REG_KD:          prdata = APB_DW'(r_kd);
            REG_MOTOR_LIMIT: prdata = APB_DW'(r_motor_limit);
            default:         prdata = '0;
        endcase
    end

    assign o_base_speed  = r_base_speed;
    assign o_motor_limit = r_motor_limit;
    assign o_gain.kp     = r_kp;
    assign o_gain.ki_q8  = r_ki_q8;
    assign o_gain.kd     = r_kd;

endmodule

// ----- rtl/core/lfp_pid.sv -----
// ----------------------------------------------------------------------------
// lfp_pid
// error decode, pid state and differential duty computation for one sample
// ----------------------------------------------------------------------------
module lfp_pid #(
    parameter int DUTY_WIDTH     = 10,
    parameter int INTEGRAL_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [lfp_pkg::SENSOR_W-1:0]      i_sensor_bits,
    input  lfp_pkg::t_gain                    i_gain,
    input  logic [DUTY_WIDTH-1:0]             i_base_speed,
    input  logic [DUTY_WIDTH-1:0]             i_motor_limit,
    output logic [DUTY_WIDTH-1:0]             o_left_duty,
    output logic [DUTY_WIDTH-1:0]             o_right_duty,
    output logic signed [lfp_pkg::ERR_W-1:0]  o_position_error
);
    import lfp_pkg::*;

    // product, numerator, control value and duty sum widths
    localparam int PW = KI_W + INTEGRAL_WIDTH;
    localparam int NW = PW + 4;
    localparam int VW = NW - 8;
    localparam int SW = ((VW > DUTY_WIDTH) ? VW : DUTY_WIDTH) + 2;
    localparam logic [INTEGRAL_WIDTH-1:0] INT_MAX = '1;

    logic signed [ERR_W-1:0]    r_last_error;
    logic [INTEGRAL_WIDTH-1:0]  r_integral;
    logic [ABS_W-1:0]           r_prev_abs;

    t_decode                    w_dec;
    logic signed [ERR_W-1:0]    w_err;
    logic                       w_zero;
    logic [ABS_W-1:0]           w_mag;
    logic [INTEGRAL_WIDTH:0]    w_sum;
    logic [INTEGRAL_WIDTH-1:0]  n_integral;
    logic [KP_W+ABS_W-1:0]      w_kp_term;
    logic signed [11:0]         w_diff;
    logic signed [11:0]         w_kd_term;
    logic signed [11:0]         w_whole;
    logic [PW-1:0]              w_prod;
    logic signed [NW-1:0]       w_num;
    logic signed [VW-1:0]       w_v;
    logic signed [SW-1:0]       w_base;
    logic signed [SW-1:0]       w_v_ext;
    logic signed [SW-1:0]       w_plus;
    logic signed [SW-1:0]       w_minus;
    logic signed [SW-1:0]       w_left;
    logic signed [SW-1:0]       w_right;
    logic signed [SW-1:0]       w_limit;

    // error selection, hold last valid error on no or multiple lines
    always_comb begin
        w_dec  = decode_sensors(i_sensor_bits);
        w_err  = w_dec.hit ? w_dec.err : r_last_error;
        w_zero = (w_err == ERR_Z);
        w_mag  = w_err[ERR_W-1] ? ABS_W'(-w_err) : ABS_W'(w_err);
    end

    // saturating integral
    always_comb begin
        w_sum      = {1'b0, r_integral} + (INTEGRAL_WIDTH+1)'(w_mag);
        n_integral = w_zero ? '0
                   : (w_sum[INTEGRAL_WIDTH] ? INT_MAX : w_sum[INTEGRAL_WIDTH-1:0]);
    end

    // pid terms, integral term scaled by 256 through the q8 gain
    always_comb begin
        w_kp_term = i_gain.kp * w_mag;
        w_diff    = $signed(12'(w_mag)) - $signed(12'(r_prev_abs));
        w_kd_term = $signed({4'b0000, i_gain.kd}) * w_diff;
        w_whole   = $signed(12'(w_kp_term)) + w_kd_term;
        w_prod    = i_gain.ki_q8 * n_integral;
        w_num     = ($signed(NW'(w_whole)) <<< 8) + $signed(NW'(w_prod));
        // divide by 256 with truncation toward zero
        w_v       = w_num[NW-1:8]
                  + $signed(VW'(w_num[NW-1] && (w_num[7:0] != 8'd0)));
    end

    // differential steering and clamp to 0..motor_limit
    always_comb begin
        w_base  = $signed(SW'(i_base_speed));
        w_limit = $signed(SW'(i_motor_limit));
        w_v_ext = SW'(w_v);
        w_plus  = w_base + w_v_ext;
        w_minus = w_base - w_v_ext;
        if (w_zero) begin
            w_left  = w_base;
            w_right = w_base;
        end else if (!w_err[ERR_W-1]) begin
            w_left  = w_plus;
            w_right = w_minus;
        end else begin
            w_left  = w_minus;
            w_right = w_plus;
        end
        priority if (w_left > w_limit) o_left_duty = i_motor_limit;
        else if (w_left < 0)           o_left_duty = '0;
        else                           o_left_duty = w_left[DUTY_WIDTH-1:0];
        priority if (w_right > w_limit) o_right_duty = i_motor_limit;
        else if (w_right < 0)           o_right_duty = '0;
        else                            o_right_duty = w_right[DUTY_WIDTH-1:0];
        o_position_error = w_err;
    end

    // controller state, advanced once per sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= ERR_Z;
            r_integral   <= '0;
            r_prev_abs   <= '0;
        end else if (i_step) begin
            if (w_dec.hit) begin
                r_last_error <= w_dec.err;
            end
            r_integral <= n_integral;
            if (!w_zero) begin
                r_prev_abs <= w_mag;
            end
        end
    end

endmodule

// ----- rtl/core/line_follower_pid_steer_top.sv -----
// Line follower steering controller. Each input word carries one sample of five
// active-low line sensors; each output word carries the left and right motor
// duties and the position error used. One sample is taken every clock cycle
// unless a stalled output has filled both registers; a result goes from the
// input register through the single-pass pid datapath into the output register.
// The user must set gains, base speed and motor limit over the apb port only
// while the stream is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// line_follower_pid_steer_top
// stream wrapper with input and output registers around the pid datapath
// ----------------------------------------------------------------------------
module line_follower_pid_steer_top #(
    parameter int DUTY_WIDTH     = 10,
    parameter int INTEGRAL_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // config port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [lfp_pkg::APB_AW-1:0]              paddr,
    input  logic [lfp_pkg::APB_DW-1:0]              pwdata,
    output logic [lfp_pkg::APB_DW-1:0]              prdata,
    output logic                                    pready,
    // sample stream
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [7:0]                              s_axis_tdata,  // sensor_bits
    // result stream
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // left_duty, right_duty, position_error, zero fill
    output logic [((2*DUTY_WIDTH+lfp_pkg::ERR_W+7)/8)*8-1:0] m_axis_tdata
);
    import lfp_pkg::*;

    localparam int OW = ((2*DUTY_WIDTH+ERR_W+7)/8)*8;
    localparam int FW = 2*DUTY_WIDTH + ERR_W;

    logic                     r_in_valid;
    logic [SENSOR_W-1:0]      r_sensor;
    logic                     r_out_valid;
    logic [OW-1:0]            r_out_data;
    logic                     w_step;
    logic [DUTY_WIDTH-1:0]    w_base_speed;
    logic [DUTY_WIDTH-1:0]    w_motor_limit;
    t_gain                    w_gain;
    logic [DUTY_WIDTH-1:0]    w_left;
    logic [DUTY_WIDTH-1:0]    w_right;
    logic signed [ERR_W-1:0]  w_err;
    logic [OW-1:0]            n_out_data;

    lfp_cfg #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_base_speed  (w_base_speed),
        .o_motor_limit (w_motor_limit),
        .o_gain        (w_gain)
    );

    lfp_pid #(
        .DUTY_WIDTH     (DUTY_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_pid (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_sensor_bits    (r_sensor),
        .i_gain           (w_gain),
        .i_base_speed     (w_base_speed),
        .i_motor_limit    (w_motor_limit),
        .o_left_duty      (w_left),
        .o_right_duty     (w_right),
        .o_position_error (w_err)
    );

    // sample moves into the output register when that slot is free or drains
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign n_out_data    = OW'({w_err, w_right, w_left});

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_sensor <= s_axis_tdata[SENSOR_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data & OW'({FW{1'b1}});

endmodule
